// File: src/dsd_pkg.sv
// ----------------------------------------------------------------------------
// Dielectric scatter package
// Shared types, constants and arithmetic step functions of the dielectric
// scatter pipeline.
// ----------------------------------------------------------------------------
package dsd_pkg;

	// Fixed-point constants.
	localparam int ONE_Q14 = 16384;
	localparam int SCHLICK_POWER = 5;
	localparam logic [15:0] IOR_RESET = 16'd6144;
	localparam logic signed [63:0] UNIT_POS = 64'(ONE_Q14);
	localparam logic signed [63:0] UNIT_NEG = -64'(ONE_Q14);
	localparam logic [56:0] ONE_Q28 = 57'd268435456;
	localparam logic [43:0] TIR_LIMIT = 44'd1073741824;

	// Number of one-bit steps of each iterative unit.
	localparam int LEN_STEPS = 32;
	localparam int RI_STEPS = 29;
	localparam int U_STEPS = 15;
	localparam int S_STEPS = 15;
	localparam int Q_STEPS = 16;
	localparam int P_STEPS = SCHLICK_POWER - 1;
	localparam int PAR_STEPS = 32;

	// Square root state: radicand shifts out two bits per step.
	typedef struct packed {
		logic [63:0] rad;
		logic [33:0] rem;
		logic [31:0] root;
	} sq_t;

	// Restoring division state: one quotient bit per step.
	typedef struct packed {
		logic [63:0] rem;
		logic [31:0] quo;
	} div_t;

	// Everything one item carries down the pipeline.
	typedef struct packed {
		logic [2:0][23:0] d;
		logic [2:0][15:0] nrm;
		logic ff;
		logic [15:0] rnd;
		logic zero;
		logic [2:0][46:0] dsq;
		sq_t lroot;
		div_t ridiv;
		div_t [2:0] udiv;
		logic [2:0][15:0] u;
		logic [2:0][31:0] un;
		logic [33:0] dot;
		logic [28:0] ri;
		logic [15:0] c;
		logic [15:0] t;
		logic [28:0] csq;
		sq_t ssq;
		div_t qdiv;
		logic [31:0] qden;
		logic [19:0] p;
		logic [16:0] r0;
		logic [43:0] tirp;
		logic tir;
		logic [24:0] refl;
		logic reflected;
		logic [2:0][31:0] cn;
		logic [2:0][47:0] dn;
		logic [2:0][30:0] v;
		logic [2:0][15:0] rf;
		logic [2:0][59:0] w;
		logic [2:0][29:0] perp;
		logic [2:0][55:0] pp;
		sq_t psq;
		logic [2:0][44:0] pn;
		logic [2:0][15:0] res;
	} pipe_t;

	// One step of the digit-by-digit integer square root.
	function automatic sq_t sqrt_step(sq_t a);
		sq_t b;
		logic [35:0] r2;
		logic [35:0] tr;
		r2 = {a.rem, a.rad[63:62]};
		tr = {2'b00, a.root, 2'b01};
		b.rad = {a.rad[61:0], 2'b00};
		if (r2 >= tr) begin
			b.rem = 34'(r2 - tr);
			b.root = {a.root[30:0], 1'b1};
		end else begin
			b.rem = r2[33:0];
			b.root = {a.root[30:0], 1'b0};
		end
		return b;
	endfunction

	// One step of restoring division producing quotient bit k.
	function automatic div_t div_step(div_t a, logic [31:0] den, int unsigned k);
		div_t b;
		logic [63:0] sh;
		sh = {32'd0, den} << k;
		b = a;
		if (a.rem >= sh) begin
			b.rem = a.rem - sh;
			b.quo[k] = 1'b1;
		end
		return b;
	endfunction

	// Shift right by sh with rounding half away from zero.
	function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int unsigned sh);
		logic [63:0] m;
		m = v[63] ? (~v + 64'd1) : v;
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return v[63] ? -$signed(m) : $signed(m);
	endfunction

	// Clamp to the unit range of Q2.14.
	function automatic logic [15:0] sat_unit(logic signed [63:0] v);
		logic [15:0] r;
		if (v > UNIT_POS) begin
			r = 16'(ONE_Q14);
		end else if (v < UNIT_NEG) begin
			r = 16'(UNIT_NEG);
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// File: src/dsd_norm.sv
// ----------------------------------------------------------------------------
// Direction normalizer
// Squares the direction, takes its length by a bit-serial square root, forms
// the front-face index ratio and divides each component by the length.
// ----------------------------------------------------------------------------
module dsd_norm import dsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic [15:0] n_eff,
	input  logic in_valid,
	input  pipe_t in_item,
	output logic out_valid,
	output pipe_t out_item
);

	logic v_s1, v_s2, v_s3, v_s4;
	pipe_t p_s1, p_s2, p_s3, p_s4;
	pipe_t n_s1, n_s2, n_s3, n_s4;
	logic len_v_sk [1:LEN_STEPS];
	pipe_t len_sk [1:LEN_STEPS];
	logic ud_v_sk [1:U_STEPS];
	pipe_t ud_sk [1:U_STEPS];

	// Valid bits travel with the data and freeze when the pipeline holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= len_v_sk[LEN_STEPS];
			v_s4 <= ud_v_sk[U_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			p_s1 <= n_s1;
			p_s2 <= n_s2;
			p_s3 <= n_s3;
			p_s4 <= n_s4;
		end
	end

	// Square each component.
	always_comb begin
		logic signed [47:0] e;
		n_s1 = in_item;
		for (int i = 0; i < 3; i++) begin
			e = 48'($signed(in_item.d[i]));
			n_s1.dsq[i] = 47'(e * e);
		end
	end

	// Sum the squares and seed the length root and the ratio divider.
	always_comb begin
		logic [47:0] len2;
		n_s2 = p_s1;
		len2 = 48'(p_s1.dsq[0]) + 48'(p_s1.dsq[1]) + 48'(p_s1.dsq[2]);
		n_s2.zero = (len2 == 48'd0);
		n_s2.lroot.rad = {len2, 16'd0};
		n_s2.lroot.rem = '0;
		n_s2.lroot.root = '0;
		n_s2.ridiv.rem = 64'd268435456 + 64'(n_eff[15:1]);
		n_s2.ridiv.quo = '0;
	end

	// Length root, one bit per stage; the ratio divider runs alongside.
	for (genvar g = 0; g < LEN_STEPS; g++) begin : g_len
		pipe_t cur;
		pipe_t nxt;
		logic cur_v;
		if (g == 0) begin : g_first
			assign cur = p_s2;
			assign cur_v = v_s2;
		end else begin : g_next
			assign cur = len_sk[g];
			assign cur_v = len_v_sk[g];
		end
		always_comb begin
			nxt = cur;
			nxt.lroot = sqrt_step(cur.lroot);
			if (g < RI_STEPS) begin
				nxt.ridiv = div_step(cur.ridiv, {16'd0, n_eff}, RI_STEPS - 1 - g);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				len_v_sk[g + 1] <= 1'b0;
			end else if (advance) begin
				len_v_sk[g + 1] <= cur_v;
			end
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				len_sk[g + 1] <= nxt;
			end
		end
	end

	// Seed the three component dividers with the rounding offset.
	always_comb begin
		logic [23:0] mag;
		n_s3 = len_sk[LEN_STEPS];
		for (int i = 0; i < 3; i++) begin
			mag = len_sk[LEN_STEPS].d[i][23] ? (~len_sk[LEN_STEPS].d[i] + 24'd1)
				: len_sk[LEN_STEPS].d[i];
			n_s3.udiv[i].rem = (64'(mag) << 22) + 64'(len_sk[LEN_STEPS].lroot.root[31:1]);
			n_s3.udiv[i].quo = '0;
		end
	end

	// Component division by the length, one quotient bit per stage.
	for (genvar g = 0; g < U_STEPS; g++) begin : g_udiv
		pipe_t cur;
		pipe_t nxt;
		logic cur_v;
		if (g == 0) begin : g_first
			assign cur = p_s3;
			assign cur_v = v_s3;
		end else begin : g_next
			assign cur = ud_sk[g];
			assign cur_v = ud_v_sk[g];
		end
		always_comb begin
			nxt = cur;
			for (int i = 0; i < 3; i++) begin
				nxt.udiv[i] = div_step(cur.udiv[i], cur.lroot.root, U_STEPS - 1 - g);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ud_v_sk[g + 1] <= 1'b0;
			end else if (advance) begin
				ud_v_sk[g + 1] <= cur_v;
			end
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				ud_sk[g + 1] <= nxt;
			end
		end
	end

	// Restore the sign and clamp to the unit range.
	always_comb begin
		logic [15:0] q;
		n_s4 = ud_sk[U_STEPS];
		for (int i = 0; i < 3; i++) begin
			q = ud_sk[U_STEPS].udiv[i].quo[15:0];
			if (q > 16'(ONE_Q14)) begin
				q = 16'(ONE_Q14);
			end
			n_s4.u[i] = ud_sk[U_STEPS].d[i][23] ? (~q + 16'd1) : q;
		end
	end

	assign out_valid = v_s4;
	assign out_item = p_s4;

endmodule

// File: src/dsd_angle.sv
// ----------------------------------------------------------------------------
// Incidence angle and reflect decision
// Forms the cosine and sine of the incidence angle, the Schlick reflectance
// and the total internal reflection test, and decides reflect or refract.
// ----------------------------------------------------------------------------
module dsd_angle import dsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic [15:0] n_eff,
	input  logic in_valid,
	input  pipe_t in_item,
	output logic out_valid,
	output pipe_t out_item
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	pipe_t p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, p_s7, p_s8;
	pipe_t n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8;
	logic sq_v_sk [1:Q_STEPS];
	pipe_t sq_sk [1:Q_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= sq_v_sk[Q_STEPS];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			p_s1 <= n_s1;
			p_s2 <= n_s2;
			p_s3 <= n_s3;
			p_s4 <= n_s4;
			p_s5 <= n_s5;
			p_s6 <= n_s6;
			p_s7 <= n_s7;
			p_s8 <= n_s8;
		end
	end

	// Products of the unit direction with the normal.
	always_comb begin
		n_s1 = in_item;
		for (int i = 0; i < 3; i++) begin
			n_s1.un[i] = 32'($signed(in_item.u[i])) * 32'($signed(in_item.nrm[i]));
		end
	end

	// Dot product and the index ratio for this face.
	always_comb begin
		n_s2 = p_s1;
		n_s2.dot = 34'($signed(p_s1.un[0])) + 34'($signed(p_s1.un[1]))
			+ 34'($signed(p_s1.un[2]));
		n_s2.ri = p_s1.ff ? p_s1.ridiv.quo[28:0] : {9'd0, n_eff, 4'd0};
	end

	// Cosine of the incidence angle, clamped to one.
	always_comb begin
		logic signed [63:0] r;
		n_s3 = p_s2;
		r = round_shift(-64'($signed(p_s2.dot)), 14);
		n_s3.c = sat_unit(r);
	end

	// Cosine squared, Schlick base and the reflectance divider seed.
	always_comb begin
		logic signed [31:0] cc;
		logic signed [17:0] tt;
		logic [28:0] num;
		logic [31:0] den;
		n_s4 = p_s3;
		cc = 32'($signed(p_s3.c)) * 32'($signed(p_s3.c));
		n_s4.csq = cc[28:0];
		tt = 18'sd16384 - 18'($signed(p_s3.c));
		n_s4.t = tt[15:0];
		n_s4.p = 20'(tt[15:0]);
		num = (p_s3.ri > 29'd65536) ? (p_s3.ri - 29'd65536) : (29'd65536 - p_s3.ri);
		den = 32'(p_s3.ri) + 32'd65536;
		n_s4.qden = den;
		n_s4.qdiv.rem = (64'(num) << 16) + 64'(den >> 1);
		n_s4.qdiv.quo = '0;
	end

	// Seed the sine root with one minus cosine squared.
	always_comb begin
		n_s5 = p_s4;
		n_s5.ssq.rad = {30'(29'd268435456 - p_s4.csq), 34'd0};
		n_s5.ssq.rem = '0;
		n_s5.ssq.root = '0;
	end

	// Sine root, reflectance divider and the Schlick power run side by side.
	for (genvar g = 0; g < Q_STEPS; g++) begin : g_ang
		pipe_t cur;
		pipe_t nxt;
		logic cur_v;
		if (g == 0) begin : g_first
			assign cur = p_s5;
			assign cur_v = v_s5;
		end else begin : g_next
			assign cur = sq_sk[g];
			assign cur_v = sq_v_sk[g];
		end
		always_comb begin
			logic [35:0] pt;
			nxt = cur;
			nxt.qdiv = div_step(cur.qdiv, cur.qden, Q_STEPS - 1 - g);
			if (g < S_STEPS) begin
				nxt.ssq = sqrt_step(cur.ssq);
			end
			if (g < P_STEPS) begin
				pt = 36'(cur.p) * 36'(cur.t);
				nxt.p = 20'((pt + 36'd8192) >> 14);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_sk[g + 1] <= 1'b0;
			end else if (advance) begin
				sq_v_sk[g + 1] <= cur_v;
			end
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				sq_sk[g + 1] <= nxt;
			end
		end
	end

	// Normal-incidence reflectance and the total reflection product.
	always_comb begin
		logic [32:0] qsq;
		logic [15:0] qq;
		n_s6 = sq_sk[Q_STEPS];
		qq = sq_sk[Q_STEPS].qdiv.quo[15:0];
		qsq = 33'(qq) * 33'(qq) + 33'd32768;
		n_s6.r0 = qsq[32:16];
		n_s6.tirp = 44'(sq_sk[Q_STEPS].ri) * 44'(sq_sk[Q_STEPS].ssq.root[14:0]);
	end

	// Schlick reflectance.
	always_comb begin
		logic [39:0] prod;
		n_s7 = p_s6;
		prod = 40'(17'h10000 - p_s6.r0) * 40'({p_s6.p, 2'b00}) + 40'd32768;
		n_s7.refl = 25'(prod[39:16]) + 25'(p_s6.r0);
		n_s7.tir = (p_s6.tirp > TIR_LIMIT);
	end

	// Reflect on total internal reflection or when reflectance wins the draw.
	always_comb begin
		n_s8 = p_s7;
		n_s8.reflected = p_s7.tir || (p_s7.refl > 25'(p_s7.rnd));
	end

	assign out_valid = v_s8;
	assign out_item = p_s8;

endmodule

// File: src/dsd_dir.sv
// ----------------------------------------------------------------------------
// Scattered direction
// Builds the mirror direction and the Snell refraction, whose parallel part
// needs a bit-serial square root, and selects the result.
// ----------------------------------------------------------------------------
module dsd_dir import dsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic in_valid,
	input  pipe_t in_item,
	output logic out_valid,
	output pipe_t out_item
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	pipe_t p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, p_s7, p_s8;
	pipe_t n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8;
	logic par_v_sk [1:PAR_STEPS];
	pipe_t par_sk [1:PAR_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= par_v_sk[PAR_STEPS];
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			p_s1 <= n_s1;
			p_s2 <= n_s2;
			p_s3 <= n_s3;
			p_s4 <= n_s4;
			p_s5 <= n_s5;
			p_s6 <= n_s6;
			p_s7 <= n_s7;
			p_s8 <= n_s8;
		end
	end

	// Cosine and dot product times the normal.
	always_comb begin
		n_s1 = in_item;
		for (int i = 0; i < 3; i++) begin
			n_s1.cn[i] = 32'($signed(in_item.c)) * 32'($signed(in_item.nrm[i]));
			n_s1.dn[i] = 48'($signed(in_item.dot)) * 48'($signed(in_item.nrm[i]));
		end
	end

	// Mirror direction, and the refraction term before the ratio.
	always_comb begin
		logic signed [63:0] r;
		n_s2 = p_s1;
		for (int i = 0; i < 3; i++) begin
			n_s2.v[i] = (31'($signed(p_s1.u[i])) <<< 14) + 31'($signed(p_s1.cn[i]));
			r = (64'($signed(p_s1.u[i])) <<< 28) - (64'($signed(p_s1.dn[i])) <<< 1);
			n_s2.rf[i] = sat_unit(round_shift(r, 28));
		end
	end

	// Scale by the index ratio.
	always_comb begin
		n_s3 = p_s2;
		for (int i = 0; i < 3; i++) begin
			n_s3.w[i] = 60'($signed({1'b0, p_s2.ri})) * 60'($signed(p_s2.v[i]));
		end
	end

	// Perpendicular part of the refracted ray.
	always_comb begin
		logic signed [63:0] r;
		n_s4 = p_s3;
		for (int i = 0; i < 3; i++) begin
			r = round_shift(64'($signed(p_s3.w[i])), 30);
			n_s4.perp[i] = r[29:0];
		end
	end

	// Squares of the perpendicular part.
	always_comb begin
		logic signed [59:0] e;
		n_s5 = p_s4;
		for (int i = 0; i < 3; i++) begin
			e = 60'($signed(p_s4.perp[i]));
			n_s5.pp[i] = 56'(e * e);
		end
	end

	// Seed the parallel root with the distance of the squared length from one.
	always_comb begin
		logic [56:0] lsq;
		logic [56:0] m;
		n_s6 = p_s5;
		lsq = 57'(p_s5.pp[0]) + 57'(p_s5.pp[1]) + 57'(p_s5.pp[2]);
		m = (lsq > ONE_Q28) ? (lsq - ONE_Q28) : (ONE_Q28 - lsq);
		n_s6.psq.rad = 64'(m);
		n_s6.psq.rem = '0;
		n_s6.psq.root = '0;
	end

	// Parallel part root, one bit per stage.
	for (genvar g = 0; g < PAR_STEPS; g++) begin : g_par
		pipe_t cur;
		pipe_t nxt;
		logic cur_v;
		if (g == 0) begin : g_first
			assign cur = p_s6;
			assign cur_v = v_s6;
		end else begin : g_next
			assign cur = par_sk[g];
			assign cur_v = par_v_sk[g];
		end
		always_comb begin
			nxt = cur;
			nxt.psq = sqrt_step(cur.psq);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				par_v_sk[g + 1] <= 1'b0;
			end else if (advance) begin
				par_v_sk[g + 1] <= cur_v;
			end
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				par_sk[g + 1] <= nxt;
			end
		end
	end

	// Parallel part times the normal.
	always_comb begin
		n_s7 = par_sk[PAR_STEPS];
		for (int i = 0; i < 3; i++) begin
			n_s7.pn[i] = 45'($signed({1'b0, par_sk[PAR_STEPS].psq.root[28:0]}))
				* 45'($signed(par_sk[PAR_STEPS].nrm[i]));
		end
	end

	// Select the result; a zero direction gives an all-zero result.
	always_comb begin
		logic signed [63:0] r;
		n_s8 = p_s7;
		for (int i = 0; i < 3; i++) begin
			r = 64'($signed(p_s7.perp[i])) - round_shift(64'($signed(p_s7.pn[i])), 14);
			if (p_s7.zero) begin
				n_s8.res[i] = '0;
			end else if (p_s7.reflected) begin
				n_s8.res[i] = p_s7.rf[i];
			end else begin
				n_s8.res[i] = sat_unit(r);
			end
		end
		n_s8.reflected = p_s7.reflected && !p_s7.zero;
	end

	assign out_valid = v_s8;
	assign out_item = p_s8;

endmodule

// File: src/dielectric_scatter_direction.sv
// ----------------------------------------------------------------------------
// Dielectric scatter direction
// Snell refraction with Schlick reflectance for a glass-like surface.
// ----------------------------------------------------------------------------
// The block takes one ray hit per clock while not stalled and returns one
// scattered direction per hit, in order. The bit-serial units are laid out
// as pipeline stages: the 32-stage length root with the ratio divider beside
// it, the 15-stage component divider, the 16-stage sine root and reflectance
// divider, and the 32-stage root of the refracted parallel part. A stall on
// the result side while a result waits freezes the whole pipeline, including
// the output register, and is passed to the hit side in the same cycle. The
// refraction index is to be written over its own port while no hit is in
// flight; the block itself does not enforce this. The port is always ready.
module dielectric_scatter_direction import dsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic hit_valid,
	output logic hit_stall,
	input  logic signed [23:0] dir_x,
	input  logic signed [23:0] dir_y,
	input  logic signed [23:0] dir_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic hit_outside,
	input  logic [15:0] random_fraction,
	output logic scatter_valid,
	input  logic scatter_stall,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic reflected,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] index_of_refraction
);

	logic [15:0] ior_q;
	logic [15:0] n_eff;
	logic advance;
	pipe_t hit_item;
	logic norm_valid, ang_valid, dir_valid;
	pipe_t norm_item, ang_item, dir_item;
	logic scatter_valid_q;
	logic [15:0] out_x_q, out_y_q, out_z_q;
	logic reflected_q;

	// Refraction index register; a zero index counts as one LSB.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ior_q <= IOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ior_q <= index_of_refraction;
		end
	end
	assign cfg_ready = 1'b1;
	assign n_eff = (ior_q == 16'd0) ? 16'd1 : ior_q;

	// The pipeline moves unless a finished transaction waits at the output.
	assign advance = !(scatter_valid_q && scatter_stall);
	assign hit_stall = !advance;

	// Pack the incoming transaction.
	always_comb begin
		hit_item = '0;
		hit_item.d[0] = dir_x;
		hit_item.d[1] = dir_y;
		hit_item.d[2] = dir_z;
		hit_item.nrm[0] = normal_x;
		hit_item.nrm[1] = normal_y;
		hit_item.nrm[2] = normal_z;
		hit_item.ff = hit_outside;
		hit_item.rnd = random_fraction;
	end

	dsd_norm u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.n_eff(n_eff),
		.in_valid(hit_valid),
		.in_item(hit_item),
		.out_valid(norm_valid),
		.out_item(norm_item)
	);

	dsd_angle u_angle (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.n_eff(n_eff),
		.in_valid(norm_valid),
		.in_item(norm_item),
		.out_valid(ang_valid),
		.out_item(ang_item)
	);

	dsd_dir u_dir (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.in_valid(ang_valid),
		.in_item(ang_item),
		.out_valid(dir_valid),
		.out_item(dir_item)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scatter_valid_q <= 1'b0;
		end else if (advance) begin
			scatter_valid_q <= dir_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_x_q <= dir_item.res[0];
			out_y_q <= dir_item.res[1];
			out_z_q <= dir_item.res[2];
			reflected_q <= dir_item.reflected;
		end
	end

	assign scatter_valid = scatter_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_z = out_z_q;
	assign reflected = reflected_q;

	// A held pipeline keeps its last stage unchanged.
	a_hold_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(dir_valid))
		else $error("pipeline moved while held");

	// A finished item reaches the output register in the next cycle.
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance && dir_valid |=> scatter_valid)
		else $error("finished transaction did not reach the output");

endmodule
